@@ rtl/phf_pkg.sv @@
// ============================================================================
// phf_pkg
// Shared widths, command and register codes, and the elaboration-time
// functions that build the orthonormal basis table.
// ============================================================================
package phf_pkg;

    localparam int CMD_W      = 2;
    localparam int BIN_W      = 10;
    localparam int WORD_W     = 24;
    localparam int VALUE_W    = 48;
    localparam int DEG_W      = 3;
    localparam int DEG_LIM    = 8;
    localparam int PROD_W     = 48;
    localparam int TERM_W     = 50;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;
    localparam int RES_DEPTH  = 8;
    localparam int RES_PTR_W  = 3;
    localparam int RES_CNT_W  = 4;

    localparam longint VALUE_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint VALUE_MIN = -VALUE_MAX - 64'sd1;
    localparam longint WORD_MAX  = 64'sd8388607;
    localparam longint WORD_MIN  = -64'sd8388608;

    localparam logic [DEG_W-1:0] DEG_RESET = 3'd4;

    typedef enum logic [CMD_W-1:0] {
        CMD_RECORD = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE       = 1'd0,
        CFG_DEGREE_COUNT = 1'd1
    } t_cfg_idx;

    typedef logic signed [WORD_W-1:0]  t_word;
    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic signed [TERM_W-1:0]  t_term;
    typedef logic        [PROD_W-1:0]  t_prod;

    function automatic logic [127:0] udivmod(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], num[i]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return {q, r[63:0]};
    endfunction

    function automatic logic [63:0] frac60(input logic [63:0] num, input logic [63:0] den);
        logic [127:0] qr;
        logic [63:0]  q;
        logic [63:0]  r;
        qr = udivmod(num, den);
        q  = qr[127:64];
        r  = qr[63:0];
        for (int i = 0; i < 60; i++) begin
            q = q << 1;
            r = r << 1;
            if (r >= den) begin
                r    = r - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] bv;
        x  = v;
        r  = '0;
        bv = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (bv > x) bv = bv >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (bv != 64'd0) begin
                if (x >= r + bv) begin
                    x = x - (r + bv);
                    r = (r >> 1) + bv;
                end else begin
                    r = r >> 1;
                end
                bv = bv >> 2;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] mag64(input longint v);
        logic [63:0] u;
        u = v;
        return (v < 0) ? (64'd0 - u) : u;
    endfunction

    function automatic longint round_shift(input longint v, input int s);
        logic [63:0] m;
        m = (mag64(v) + (64'd1 << (s - 1))) >> s;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [63:0] basis_q0(input int n);
        return isqrt64(frac60(64'd1, 64'(n)));
    endfunction

    function automatic logic [DEG_LIM*64-1:0] basis_bk(input int n, input int maxdeg);
        logic [DEG_LIM*64-1:0] res;
        logic [63:0] nn;
        logic [63:0] kk;
        logic [63:0] k1;
        logic [63:0] d1;
        res = '0;
        nn  = 64'(n);
        for (int k = 0; k < DEG_LIM; k++) begin
            kk = 64'(k);
            k1 = kk + 64'd1;
            d1 = nn * nn - k1 * k1;
            if (k + 1 < maxdeg) begin
                res[k*64 +: 64] = isqrt64(frac60(
                    (64'd2 * kk + 64'd1) * (64'd2 * kk + 64'd3) * (nn - 64'd1) * (nn - 64'd1),
                    d1 * k1 * k1));
            end
        end
        return res;
    endfunction

    function automatic logic [DEG_LIM*64-1:0] basis_ck(input int n, input int maxdeg);
        logic [DEG_LIM*64-1:0] res;
        logic [63:0] nn;
        logic [63:0] kk;
        logic [63:0] k1;
        logic [63:0] d1;
        res = '0;
        nn  = 64'(n);
        for (int k = 1; k < DEG_LIM; k++) begin
            kk = 64'(k);
            k1 = kk + 64'd1;
            d1 = nn * nn - k1 * k1;
            if (k + 1 < maxdeg) begin
                res[k*64 +: 64] = isqrt64(frac60(
                    kk * kk * (nn * nn - kk * kk) * (64'd2 * kk + 64'd3),
                    k1 * k1 * d1 * (64'd2 * kk - 64'd1)));
            end
        end
        return res;
    endfunction

    function automatic logic [DEG_LIM*WORD_W-1:0] basis_row(
        input int                    n,
        input int                    maxdeg,
        input logic [63:0]           q0,
        input logic [DEG_LIM*64-1:0] bk,
        input logic [DEG_LIM*64-1:0] ck,
        input int                    bin_idx
    );
        logic [DEG_LIM*WORD_W-1:0] row;
        logic [127:0] qr;
        logic [63:0]  nm1;
        logic [63:0]  mz;
        logic [63:0]  az;
        longint       z;
        longint       prev;
        longint       cur;
        longint       nxt;
        longint       m;
        longint       wrd;
        row  = '0;
        nm1  = 64'(n - 1);
        z    = 2 * longint'(bin_idx) - longint'(nm1);
        mz   = mag64(z);
        prev = 0;
        cur  = longint'(q0);
        for (int k = 0; k < DEG_LIM; k++) begin
            if (k < maxdeg) begin
                wrd = round_shift(cur, 8);
                if (wrd > WORD_MAX) wrd = WORD_MAX;
                if (wrd < WORD_MIN) wrd = WORD_MIN;
                row[k*WORD_W +: WORD_W] = wrd[WORD_W-1:0];
                if (k + 1 < maxdeg) begin
                    qr  = udivmod(bk[k*64 +: 64] * mz + (nm1 >> 1), nm1);
                    az  = qr[127:64];
                    m   = (z < 0) ? -longint'(az) : longint'(az);
                    nxt = round_shift(m * cur, 30);
                    if (k >= 1) nxt = nxt - round_shift(longint'(ck[k*64 +: 64]) * prev, 30);
                    prev = cur;
                    cur  = nxt;
                end
            end
        end
        return row;
    endfunction

endpackage

@@ rtl/polynomial_histogram_fit_top.sv @@
// ============================================================================
// polynomial_histogram_fit_top
// Orthogonal polynomial fit of a bin histogram: record words add a bin's
// basis row to the coefficients, query words return the fitted value, clear words zero them.
// ============================================================================
//
//   channel   handshake              payload
//   input     i_valid / o_stall      i_cmd, i_bin
//   output    o_valid / i_stall      o_fitted_value, o_saturated
//   config    i_cfg_we               i_cfg_idx, i_cfg_data
//
// One word per cycle while o_stall is low; a query result passes the basis
// ROM read, two multiplier stages and the adder tree into the result queue.
// Coefficients update in the cycle after the ROM read, so back-to-back words
// see each other's effect without interlock.
// Reset zeroes coefficients and flags; ROM contents need no fill pass.
// Up to 8 query results may be outstanding; o_stall rises once 8 are.
//
module polynomial_histogram_fit_top #(
    parameter int NUM_BINS   = 1024,
    parameter int MAX_DEGREE = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [phf_pkg::CMD_W-1:0]         i_cmd,
    input  logic [phf_pkg::BIN_W-1:0]         i_bin,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [phf_pkg::VALUE_W-1:0] o_fitted_value,
    output logic                              o_saturated,
    input  logic                              i_cfg_we,
    input  logic [phf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [phf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import phf_pkg::*;

    localparam int ADDR_W = $clog2(NUM_BINS);
    localparam int ROW_W  = MAX_DEGREE * WORD_W;
    localparam int SUM_W  = TERM_W + $clog2(MAX_DEGREE) + 1;

    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(VALUE_MAX);
    localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(VALUE_MIN);
    localparam logic [RES_CNT_W-1:0]    RES_FULL = RES_CNT_W'(RES_DEPTH);

    logic                  r_run;
    logic                  r_enable;
    logic [DEG_W-1:0]      r_degree_count;

    logic                  w_in_acc;
    logic                  w_out_acc;
    logic                  w_bin_ok;
    logic [ADDR_W-1:0]     w_addr;
    logic [ROW_W-1:0]      w_row;

    logic                  r_s1_rec;
    logic                  r_s1_qry;
    logic                  r_s1_clr;
    logic                  r_s1_bin_ok;

    t_value                r_coef   [MAX_DEGREE];
    t_value                n_coef   [MAX_DEGREE];
    logic signed [VALUE_W:0] w_csum [MAX_DEGREE];
    t_word                 w_word   [MAX_DEGREE];
    logic                  r_sat_seen;
    logic                  n_sat_seen;

    t_prod                 n_p_hi   [MAX_DEGREE];
    t_prod                 n_p_lo   [MAX_DEGREE];
    logic                  n_neg    [MAX_DEGREE];
    logic                  n_en     [MAX_DEGREE];
    t_prod                 r_p_hi   [MAX_DEGREE];
    t_prod                 r_p_lo   [MAX_DEGREE];
    logic                  r_neg    [MAX_DEGREE];
    logic                  r_en     [MAX_DEGREE];
    logic [VALUE_W-1:0]    w_mc     [MAX_DEGREE];
    logic [WORD_W-1:0]     w_mw     [MAX_DEGREE];
    logic                  r_s2_qry;
    logic                  r_s2_sat;

    t_term                 n_term   [MAX_DEGREE];
    t_term                 r_term   [MAX_DEGREE];
    logic [TERM_W-1:0]     w_umag   [MAX_DEGREE];
    logic                  r_s3_qry;
    logic                  r_s3_sat;

    logic signed [SUM_W-1:0] w_sum;
    t_value                w_result;
    logic                  w_result_sat;

    t_value                r_fifo_val [RES_DEPTH];
    logic                  r_fifo_sat [RES_DEPTH];
    logic [RES_PTR_W-1:0]  r_wr_ptr;
    logic [RES_PTR_W-1:0]  r_rd_ptr;
    logic [RES_CNT_W-1:0]  r_count;
    logic [RES_CNT_W-1:0]  r_credit;
    logic [RES_CNT_W-1:0]  n_credit;
    logic [RES_CNT_W-1:0]  n_count;

    // handshake
    assign o_stall   = !r_run || (r_credit == RES_FULL);
    assign w_in_acc  = i_valid && !o_stall;
    assign o_valid   = (r_count != '0);
    assign w_out_acc = o_valid && !i_stall;

    assign w_bin_ok = (int'(i_bin) < NUM_BINS);
    assign w_addr   = w_bin_ok ? ADDR_W'(i_bin) : '0;

    phf_basis_rom #(
        .NUM_BINS   (NUM_BINS),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (w_addr),
        .o_row  (w_row)
    );

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run          <= 1'b0;
            r_enable       <= 1'b0;
            r_degree_count <= DEG_RESET;
        end else begin
            r_run <= 1'b1;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ENABLE:       r_enable       <= i_cfg_data[0];
                    CFG_DEGREE_COUNT: r_degree_count <= i_cfg_data;
                    default:          r_enable       <= r_enable;
                endcase
            end
        end
    end

    // stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_rec <= 1'b0;
            r_s1_qry <= 1'b0;
            r_s1_clr <= 1'b0;
        end else begin
            r_s1_rec <= w_in_acc && (i_cmd == CMD_RECORD);
            r_s1_qry <= w_in_acc && (i_cmd == CMD_QUERY);
            r_s1_clr <= w_in_acc && (i_cmd == CMD_CLEAR);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_bin_ok <= w_bin_ok;
    end

    // stage 1: coefficient update and partial products
    always_comb begin
        n_sat_seen = r_sat_seen;
        for (int k = 0; k < MAX_DEGREE; k++) begin
            w_word[k] = t_word'(w_row[k*WORD_W +: WORD_W]);
            w_csum[k] = {r_coef[k][VALUE_W-1], r_coef[k]}
                      + {{(VALUE_W+1-WORD_W){w_word[k][WORD_W-1]}}, w_word[k]};
            n_coef[k] = r_coef[k];
            if (r_s1_clr) begin
                n_coef[k] = '0;
            end else if (r_s1_rec && r_enable && r_s1_bin_ok) begin
                if (w_csum[k][VALUE_W] != w_csum[k][VALUE_W-1]) begin
                    n_coef[k]  = w_csum[k][VALUE_W] ? t_value'(VALUE_MIN) : t_value'(VALUE_MAX);
                    n_sat_seen = 1'b1;
                end else begin
                    n_coef[k] = w_csum[k][VALUE_W-1:0];
                end
            end
        end
        if (r_s1_clr) n_sat_seen = 1'b0;
    end

    always_comb begin
        for (int k = 0; k < MAX_DEGREE; k++) begin
            w_mc[k]   = r_coef[k][VALUE_W-1] ? (VALUE_W'(0) - r_coef[k]) : r_coef[k];
            w_mw[k]   = w_word[k][WORD_W-1] ? (WORD_W'(0) - w_word[k]) : w_word[k];
            n_p_hi[k] = {{(PROD_W-WORD_W){1'b0}}, w_mc[k][VALUE_W-1:WORD_W]}
                      * {{(PROD_W-WORD_W){1'b0}}, w_mw[k]};
            n_p_lo[k] = {{(PROD_W-WORD_W){1'b0}}, w_mc[k][WORD_W-1:0]}
                      * {{(PROD_W-WORD_W){1'b0}}, w_mw[k]};
            n_neg[k]  = r_coef[k][VALUE_W-1] ^ w_word[k][WORD_W-1];
            n_en[k]   = r_s1_bin_ok && (k < int'(r_degree_count));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat_seen <= 1'b0;
            for (int k = 0; k < MAX_DEGREE; k++) r_coef[k] <= '0;
        end else begin
            r_sat_seen <= n_sat_seen;
            for (int k = 0; k < MAX_DEGREE; k++) r_coef[k] <= n_coef[k];
        end
    end

    // stage 2: rounded signed terms
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_DEGREE; k++) begin
            r_p_hi[k] <= n_p_hi[k];
            r_p_lo[k] <= n_p_lo[k];
            r_neg[k]  <= n_neg[k];
            r_en[k]   <= n_en[k];
        end
        r_s2_sat <= r_sat_seen;
    end

    always_comb begin
        for (int k = 0; k < MAX_DEGREE; k++) begin
            w_umag[k] = {r_p_hi[k], 2'b00}
                      + ((TERM_W'(r_p_lo[k]) + (TERM_W'(1) << 21)) >> 22);
            if (!r_en[k]) begin
                n_term[k] = '0;
            end else if (r_neg[k]) begin
                n_term[k] = t_term'(TERM_W'(0) - w_umag[k]);
            end else begin
                n_term[k] = t_term'(w_umag[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_DEGREE; k++) r_term[k] <= n_term[k];
        r_s3_sat <= r_s2_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_qry <= 1'b0;
            r_s3_qry <= 1'b0;
        end else begin
            r_s2_qry <= r_s1_qry;
            r_s3_qry <= r_s2_qry;
        end
    end

    // stage 3: sum and saturate
    always_comb begin
        w_sum = '0;
        for (int k = 0; k < MAX_DEGREE; k++) begin
            w_sum = w_sum + SUM_W'(r_term[k]);
        end
        w_result_sat = r_s3_sat;
        if (w_sum > SUM_MAX) begin
            w_result     = t_value'(VALUE_MAX);
            w_result_sat = 1'b1;
        end else if (w_sum < SUM_MIN) begin
            w_result     = t_value'(VALUE_MIN);
            w_result_sat = 1'b1;
        end else begin
            w_result = w_sum[VALUE_W-1:0];
        end
    end

    // result queue
    always_ff @(posedge i_clk) begin
        if (r_s3_qry) begin
            r_fifo_val[r_wr_ptr] <= w_result;
            r_fifo_sat[r_wr_ptr] <= w_result_sat;
        end
    end

    always_comb begin
        n_count  = r_count;
        n_credit = r_credit;
        if (r_s3_qry) n_count = n_count + 1'b1;
        if (w_out_acc) begin
            n_count  = n_count - 1'b1;
            n_credit = n_credit - 1'b1;
        end
        if (w_in_acc && (i_cmd == CMD_QUERY)) n_credit = n_credit + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_credit <= '0;
        end else begin
            if (r_s3_qry)  r_wr_ptr <= r_wr_ptr + 1'b1;
            if (w_out_acc) r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count  <= n_count;
            r_credit <= n_credit;
        end
    end

    assign o_fitted_value = r_fifo_val[r_rd_ptr];
    assign o_saturated    = r_fifo_sat[r_rd_ptr];

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= RES_FULL)
        else $error("result queue overfilled");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_qry |-> (r_count < RES_FULL) || w_out_acc)
        else $error("result pushed into full queue");

    a_credit_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_credit)
        else $error("queued results exceed outstanding queries");

    a_clear_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_clr |=> (r_sat_seen == 1'b0) && (r_coef[0] == '0))
        else $error("clear did not reset coefficients");

endmodule

@@ rtl/phf_basis_rom.sv @@
// ============================================================================
// phf_basis_rom
// Basis table: one row per bin holding every degree's Q1.22 word, contents
// fixed at elaboration, registered read.
// ============================================================================
module phf_basis_rom #(
    parameter int NUM_BINS   = 1024,
    parameter int MAX_DEGREE = 4
) (
    input  logic                                  i_clk,
    input  logic [$clog2(NUM_BINS)-1:0]           i_addr,
    output logic [MAX_DEGREE*phf_pkg::WORD_W-1:0] o_row
);
    import phf_pkg::*;

    localparam int ROW_W = MAX_DEGREE * WORD_W;

    localparam logic [63:0]           Q0 = basis_q0(NUM_BINS);
    localparam logic [DEG_LIM*64-1:0] BK = basis_bk(NUM_BINS, MAX_DEGREE);
    localparam logic [DEG_LIM*64-1:0] CK = basis_ck(NUM_BINS, MAX_DEGREE);

    logic [ROW_W-1:0] rom [NUM_BINS];
    logic [ROW_W-1:0] r_row;

    for (genvar b = 0; b < NUM_BINS; b++) begin : g_bin
        localparam logic [DEG_LIM*WORD_W-1:0] ROW =
            basis_row(NUM_BINS, MAX_DEGREE, Q0, BK, CK, b);
        assign rom[b] = ROW[ROW_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_row <= rom[i_addr];
    end

    assign o_row = r_row;

endmodule

@@ tb/tb_polynomial_histogram_fit_top.sv @@
// ============================================================================
// tb_polynomial_histogram_fit_top
// Drives record, query, clear and reserved words into the histogram fit block
// under several enable and degree settings, with random gaps and stalls on
// both channels. A local copy of the basis table and the coefficients
// predicts every query result, which is checked field by field.
// ============================================================================
module tb_polynomial_histogram_fit_top;
    import phf_pkg::*;

    localparam int NUM_BINS       = 1024;
    localparam int MAX_DEGREE     = 4;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_WORDS    = 225;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [BIN_W-1:0] bin;
    } fit_word_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      sat;
    } fit_result_t;

    logic                         i_clk      = 1'b0;
    logic                         i_rst_n    = 1'b0;
    logic                         i_valid    = 1'b0;
    logic                         o_stall;
    logic [CMD_W-1:0]             i_cmd      = '0;
    logic [BIN_W-1:0]             i_bin      = '0;
    logic                         o_valid;
    logic                         i_stall    = 1'b0;
    logic signed [VALUE_W-1:0]    o_fitted_value;
    logic                         o_saturated;
    logic                         i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]         i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0]        i_cfg_data = '0;

    fit_word_t   word_queue[$];
    fit_result_t fit_expected[$];
    fit_result_t fit_want;

    t_word       basis_rom [MAX_DEGREE][NUM_BINS];
    longint      fit_coef [MAX_DEGREE];
    logic        sat_sticky  = 1'b0;
    logic        cfg_enable  = 1'b0;
    logic [2:0]  cfg_degrees = 3'd4;

    logic        steady       = 1'b0;
    int          mismatches   = 0;
    int          quiet_cycles = 0;

    logic [2:0]  degree_plan [RANDOM_PHASES] = '{3'd4, 3'd1, 3'd0, 3'd7, 3'd3, 3'd2, 3'd4, 3'd5};

    polynomial_histogram_fit_top #(
        .NUM_BINS   (NUM_BINS),
        .MAX_DEGREE (MAX_DEGREE)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_bin          (i_bin),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_fitted_value (o_fitted_value),
        .o_saturated    (o_saturated),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] frac_q60(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = num / den;
        r = num % den;
        for (int i = 0; i < 60; i++) begin
            q = q << 1;
            r = r << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] sqrt_floor(input logic [63:0] v);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = v;
        r = '0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 64'd0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] abs_u64(input longint v);
        logic [63:0] u;
        u = v;
        return (v < 0) ? (64'd0 - u) : u;
    endfunction

    function automatic longint round_away(input longint v, input int s);
        logic [63:0] m;
        m = (abs_u64(v) + (64'd1 << (s - 1))) >> s;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clamp48(input longint v, output logic hit);
        hit = 1'b0;
        if (v > VALUE_MAX) begin
            hit = 1'b1;
            return VALUE_MAX;
        end
        if (v < VALUE_MIN) begin
            hit = 1'b1;
            return VALUE_MIN;
        end
        return v;
    endfunction

    // discrete Chebyshev recurrence in Q.30, words rounded to Q1.22
    function automatic void build_basis_rom();
        logic [63:0] n;
        logic [63:0] kk;
        logic [63:0] k1;
        logic [63:0] d1;
        logic [63:0] az;
        logic [63:0] bk [MAX_DEGREE];
        logic [63:0] ck [MAX_DEGREE];
        longint      q0;
        longint      z;
        longint      prev;
        longint      cur;
        longint      nxt;
        longint      m;
        longint      w;
        n  = 64'(NUM_BINS);
        q0 = longint'(sqrt_floor(frac_q60(64'd1, n)));
        for (int k = 0; k < MAX_DEGREE; k++) begin
            kk = 64'(k);
            k1 = kk + 64'd1;
            d1 = n * n - k1 * k1;
            bk[k] = '0;
            ck[k] = '0;
            if (k1 < 64'(MAX_DEGREE)) begin
                bk[k] = sqrt_floor(frac_q60(
                    (2 * kk + 1) * (2 * kk + 3) * (n - 1) * (n - 1), d1 * k1 * k1));
                if (k >= 1)
                    ck[k] = sqrt_floor(frac_q60(
                        kk * kk * (n * n - kk * kk) * (2 * kk + 3),
                        k1 * k1 * d1 * (2 * kk - 1)));
            end
        end
        for (int i = 0; i < NUM_BINS; i++) begin
            z    = 2 * longint'(i) - longint'(n - 1);
            prev = 0;
            cur  = q0;
            for (int k = 0; k < MAX_DEGREE; k++) begin
                w = round_away(cur, 8);
                if (w > WORD_MAX) w = WORD_MAX;
                if (w < WORD_MIN) w = WORD_MIN;
                basis_rom[k][i] = w[WORD_W-1:0];
                if (k + 1 < MAX_DEGREE) begin
                    az  = (bk[k] * abs_u64(z) + (n - 1) / 2) / (n - 1);
                    m   = (z < 0) ? -longint'(az) : longint'(az);
                    nxt = round_away(m * cur, 30);
                    if (k >= 1) nxt = nxt - round_away(longint'(ck[k]) * prev, 30);
                    prev = cur;
                    cur  = nxt;
                end
            end
        end
    endfunction

    function automatic void model_word(input logic [CMD_W-1:0] cmd, input logic [BIN_W-1:0] bin);
        longint       sum;
        longint       term;
        logic         hit;
        logic         h;
        int           count;
        logic [63:0]  mc;
        logic [63:0]  mw;
        logic [127:0] prod;
        fit_result_t  res;
        case (cmd)
            CMD_CLEAR: begin
                for (int k = 0; k < MAX_DEGREE; k++) fit_coef[k] = 0;
                sat_sticky = 1'b0;
            end
            CMD_RECORD: begin
                if (cfg_enable) begin
                    for (int k = 0; k < MAX_DEGREE; k++) begin
                        fit_coef[k] = clamp48(fit_coef[k] + longint'(basis_rom[k][bin]), h);
                        sat_sticky  = sat_sticky | h;
                    end
                end
            end
            CMD_QUERY: begin
                count = (cfg_degrees > MAX_DEGREE) ? MAX_DEGREE : int'(cfg_degrees);
                sum   = 0;
                for (int k = 0; k < count; k++) begin
                    mc   = abs_u64(fit_coef[k]);
                    mw   = abs_u64(basis_rom[k][bin]);
                    prod = ({64'd0, mc} * {64'd0, mw} + (128'd1 << 21)) >> 22;
                    term = longint'(prod[63:0]);
                    if ((fit_coef[k] < 0) != (basis_rom[k][bin] < 0)) term = -term;
                    sum = sum + term;
                end
                sum       = clamp48(sum, hit);
                res.value = sum[VALUE_W-1:0];
                res.sat   = sat_sticky | hit;
                fit_expected.push_back(res);
            end
            default: ;
        endcase
    endfunction

    function automatic void push_word(input logic [CMD_W-1:0] cmd, input logic [BIN_W-1:0] bin);
        fit_word_t w;
        w.cmd = cmd;
        w.bin = bin;
        word_queue.push_back(w);
    endfunction

    function automatic logic [CMD_W-1:0] pick_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 58) return CMD_RECORD;
        if (r < 94) return CMD_QUERY;
        if (r < 97) return CMD_CLEAR;
        return CMD_RESERVED;
    endfunction

    function automatic logic [BIN_W-1:0] pick_bin();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 1) ? BIN_W'(NUM_BINS - 1) : '0;
        return BIN_W'($urandom_range(0, NUM_BINS - 1));
    endfunction

    task automatic program_regs(input logic en, input logic [2:0] deg);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_ENABLE;
        i_cfg_data <= CFG_DATA_W'(en);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_DEGREE_COUNT;
        i_cfg_data <= deg;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_enable  = en;
        cfg_degrees = deg;
    endtask

    // wait out pending words and results, then let records and clears settle
    task automatic drain();
        while (word_queue.size() != 0 || i_valid || fit_expected.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                model_word(i_cmd, i_bin);
            if (!i_valid || !o_stall) begin
                if (word_queue.size() != 0 && (steady || $urandom_range(0, 99) >= 29)) begin
                    i_valid <= 1'b1;
                    i_cmd   <= word_queue[0].cmd;
                    i_bin   <= word_queue[0].bin;
                    word_queue.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (fit_expected.size() == 0) begin
                    $error("fitted_value: no result expected, got %0d", o_fitted_value);
                    mismatches++;
                end else begin
                    fit_want = fit_expected.pop_front();
                    if (o_fitted_value !== fit_want.value) begin
                        $error("fitted_value: expected %0d, got %0d",
                               fit_want.value, o_fitted_value);
                        mismatches++;
                    end
                    if (o_saturated !== fit_want.sat) begin
                        $error("saturated: expected %0b, got %0b", fit_want.sat, o_saturated);
                        mismatches++;
                    end
                end
            end
            i_stall <= !steady && ($urandom_range(0, 99) < 29);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        for (int k = 0; k < MAX_DEGREE; k++) fit_coef[k] = 0;
        build_basis_rom();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // disabled: records drop, queries still answer
        program_regs(1'b0, 3'd4);
        push_word(CMD_RECORD, 10'd0);
        push_word(CMD_QUERY, 10'd0);
        push_word(CMD_QUERY, 10'd1023);
        push_word(CMD_RESERVED, 10'd1023);
        drain();

        program_regs(1'b1, 3'd4);
        push_word(CMD_RECORD, 10'd0);
        push_word(CMD_RECORD, 10'd1023);
        push_word(CMD_RECORD, 10'd512);
        push_word(CMD_RECORD, 10'd511);
        push_word(CMD_QUERY, 10'd0);
        push_word(CMD_QUERY, 10'd1023);
        push_word(CMD_QUERY, 10'd511);
        push_word(CMD_RESERVED, 10'd0);
        push_word(CMD_QUERY, 10'd512);
        push_word(CMD_CLEAR, 10'd0);
        push_word(CMD_QUERY, 10'd0);
        push_word(CMD_RECORD, 10'd1023);
        push_word(CMD_RECORD, 10'd1023);
        push_word(CMD_QUERY, 10'd1023);
        drain();

        // empty sum
        program_regs(1'b1, 3'd0);
        push_word(CMD_QUERY, 10'd1023);
        push_word(CMD_QUERY, 10'd0);
        drain();

        // degree count above the limit clamps
        program_regs(1'b1, 3'd7);
        push_word(CMD_QUERY, 10'd0);
        push_word(CMD_RECORD, 10'd5);
        push_word(CMD_QUERY, 10'd5);
        drain();

        program_regs(1'b1, 3'd1);
        push_word(CMD_QUERY, 10'd1023);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            steady = (p == 3);
            program_regs((p == 5) ? 1'b0 : ($urandom_range(0, 9) != 0), degree_plan[p]);
            for (int i = 0; i < PHASE_WORDS; i++)
                push_word(pick_cmd(), pick_bin());
            drain();
        end
        steady = 1'b0;

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
